/* design/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg: shared constants and calendar tables
// Register indexes, reset values, field widths and month tables used by the
// date analyser and its checker.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_W  = 12;
  localparam int MON_W   = 7;
  localparam int DAY_W   = 7;
  localparam int DOY_W   = 9;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] REG_YEAR_LOW  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_YEAR_HIGH = 2'd1;

  localparam logic [YEAR_W-1:0] YEAR_LOW_RST  = 12'd1700;
  localparam logic [YEAR_W-1:0] YEAR_HIGH_RST = 12'd2100;

  localparam logic [DOY_W-1:0] DAYS_IN_YEAR = 9'd365;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_100_SH for x below 43699
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_100_SH = 19;

  // Days in month (1 to 12); lp adds the leap day to February
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = lp ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m, non-leap year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Days from 1 March to the first of month m in a March-based year
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd3:    n = 9'd0;
      4'd4:    n = 9'd31;
      4'd5:    n = 9'd61;
      4'd6:    n = 9'd92;
      4'd7:    n = 9'd122;
      4'd8:    n = 9'd153;
      4'd9:    n = 9'd184;
      4'd10:   n = 9'd214;
      4'd11:   n = 9'd245;
      4'd12:   n = 9'd275;
      4'd1:    n = 9'd306;
      4'd2:    n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* design/gregorian_date_analyzer.sv */
// ----------------------------------------------------------------------------
// gregorian_date_analyzer: date check, day of year, weekday and neighbours
// Three-stage pipeline that validates a date against a programmable year
// window and derives its calendar properties and adjacent dates.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_year, in_month, in_day               in_valid / in_ready
//  result    out_valid_res .. out_step_overflow      out_valid / out_ready
//  config    cfg_addr, cfg_wdata                     cfg_we, no wait
//
//  One item per cycle while the output is not stalled; each taken item passes
//  through stages 1, 2 and 3 in order. The depth is set by the reciprocal
//  multiplies for the divisions by 100 (stage 1), the leap and window logic
//  (stage 2) and the weekday modulo 7 fold (stage 3, output register).
//  A stalled output freezes all three stages together; nothing is dropped.
//  Synchronous reset empties the pipeline and loads the default year window.
// ----------------------------------------------------------------------------
module gregorian_date_analyzer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gda_pkg::YEAR_W-1:0]   in_year,
  input  logic [gda_pkg::MON_W-1:0]    in_month,
  input  logic [gda_pkg::DAY_W-1:0]    in_day,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_valid_res,
  output logic                         out_leap,
  output logic [gda_pkg::DOY_W-1:0]    out_day_of_year,
  output logic [gda_pkg::DOY_W-1:0]    out_days_left,
  output logic [2:0]                   out_weekday,
  output logic [gda_pkg::YEAR_W-1:0]   out_next_year,
  output logic [3:0]                   out_next_month,
  output logic [4:0]                   out_next_day,
  output logic [gda_pkg::YEAR_W-1:0]   out_prev_year,
  output logic [3:0]                   out_prev_month,
  output logic [4:0]                   out_prev_day,
  output logic [1:0]                   out_step_overflow,
  input  logic                         cfg_we,
  input  logic [gda_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [gda_pkg::YEAR_W-1:0]   cfg_wdata
);
  import gda_pkg::*;

  logic adv;

  // configuration
  logic [YEAR_W-1:0] year_low_r, year_high_r;

  // stage 1
  logic              s1_v_r;
  logic [YEAR_W-1:0] s1_y_r;
  logic [MON_W-1:0]  s1_m_r;
  logic [DAY_W-1:0]  s1_d_r;
  logic              s1_win_r;
  logic [12:0]       s1_yy_r;
  logic [5:0]        s1_qy_r;
  logic [5:0]        s1_qyy_r;
  logic [12:0]       yy_nxt;
  logic [24:0]       py_prod;
  logic [25:0]       pyy_prod;

  // stage 2
  logic              s2_v_r;
  logic              s2_ok_r;
  logic              s2_lp_r;
  logic [DOY_W-1:0]  s2_doy_r;
  logic [13:0]       s2_sum_r;
  logic [YEAR_W-1:0] s2_ny_r, s2_py_r;
  logic [3:0]        s2_nm_r, s2_pm_r;
  logic [4:0]        s2_nd_r, s2_pd_r;
  logic [1:0]        s2_ovf_r;

  logic              lp_nxt, ok_nxt, m_ok, last_day, first_day;
  logic [3:0]        m4;
  logic [4:0]        d5, mlen;
  logic [DOY_W-1:0]  doy_nxt;
  logic [13:0]       sum_nxt;
  logic [12:0]       ny_wide;
  logic [YEAR_W-1:0] py_nxt;
  logic [3:0]        nm_nxt, pm_nxt;
  logic [4:0]        nd_nxt, pd_nxt;
  logic [1:0]        ovf_nxt;

  // stage 3
  logic              out_valid_r;
  logic [5:0]        fold_a;
  logic [3:0]        fold_b;
  logic [2:0]        wd_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_low_r  <= YEAR_LOW_RST;
      year_high_r <= YEAR_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_YEAR_LOW) begin
        year_low_r <= cfg_wdata;
      end else if (cfg_addr == REG_YEAR_HIGH) begin
        year_high_r <= cfg_wdata;
      end
    end
  end

  // Stage 1: year shifted by 400 for the weekday count, and both /100 quotients
  always_comb begin
    yy_nxt   = {1'b0, in_year} + 13'd400 - ((in_month <= 7'd2) ? 13'd1 : 13'd0);
    py_prod  = {13'b0, in_year} * {12'b0, RECIP_100};
    pyy_prod = {13'b0, yy_nxt} * {13'b0, RECIP_100};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y_r   <= in_year;
      s1_m_r   <= in_month;
      s1_d_r   <= in_day;
      s1_win_r <= (in_year >= year_low_r) && (in_year <= year_high_r);
      s1_yy_r  <= yy_nxt;
      s1_qy_r  <= py_prod[RECIP_100_SH +: 6];
      s1_qyy_r <= pyy_prod[RECIP_100_SH +: 6];
    end
  end

  // Stage 2: leap flag, validity, day of year, neighbours, weekday day sum
  always_comb begin
    m4     = s1_m_r[3:0];
    d5     = s1_d_r[4:0];
    // divisible by 4, and not by 100 unless by 400
    lp_nxt = (s1_y_r[1:0] == 2'd0) &&
             ((s1_y_r != 12'(s1_qy_r * 7'd100)) || (s1_qy_r[1:0] == 2'd0));
    m_ok   = (s1_m_r >= 7'd1) && (s1_m_r <= 7'd12);
    mlen   = month_len(m_ok ? m4 : 4'd0, lp_nxt);
    ok_nxt = s1_win_r && m_ok && (s1_d_r != 7'd0) && (s1_d_r <= {2'b0, mlen});

    doy_nxt = days_before(m4) + {4'b0, d5} + {8'b0, (m4 > 4'd2) && lp_nxt};

    // 365 is 1 mod 7, so the year term counts once; +2 folds in -1 and +3
    sum_nxt = {1'b0, s1_yy_r} + {3'b0, s1_yy_r[12:2]} - {8'b0, s1_qyy_r}
            + {10'b0, s1_qyy_r[5:2]} + {5'b0, month_offset(m4)}
            + {7'b0, s1_d_r} + 14'd2;

    last_day = (d5 == mlen);
    ny_wide  = {1'b0, s1_y_r};
    nm_nxt   = m4;
    nd_nxt   = d5 + 5'd1;
    if (last_day) begin
      nd_nxt = 5'd1;
      if (m4 == 4'd12) begin
        nm_nxt  = 4'd1;
        ny_wide = {1'b0, s1_y_r} + 13'd1;
      end else begin
        nm_nxt = m4 + 4'd1;
      end
    end

    first_day = (d5 == 5'd1);
    py_nxt    = s1_y_r;
    pm_nxt    = m4;
    pd_nxt    = d5 - 5'd1;
    ovf_nxt   = 2'b00;
    if (first_day) begin
      if (m4 == 4'd1) begin
        pm_nxt = 4'd12;
        py_nxt = s1_y_r - 12'd1;
        pd_nxt = 5'd31;
        // compare on the unwrapped year: year 0 always steps out
        ovf_nxt[1] = (s1_y_r == 12'd0) || ((s1_y_r - 12'd1) < year_low_r);
      end else begin
        pm_nxt = m4 - 4'd1;
        pd_nxt = month_len(m4 - 4'd1, lp_nxt);
      end
    end
    ovf_nxt[0] = ny_wide > {1'b0, year_high_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok_r  <= ok_nxt;
      s2_lp_r  <= lp_nxt;
      s2_doy_r <= doy_nxt;
      s2_sum_r <= sum_nxt;
      s2_ny_r  <= ny_wide[YEAR_W-1:0];
      s2_nm_r  <= nm_nxt;
      s2_nd_r  <= nd_nxt;
      s2_py_r  <= py_nxt;
      s2_pm_r  <= pm_nxt;
      s2_pd_r  <= pd_nxt;
      s2_ovf_r <= ovf_nxt;
    end
  end

  // Stage 3: modulo 7 by folding octal digits (8 is 1 mod 7), zero invalid items
  always_comb begin
    fold_a = {3'b0, s2_sum_r[2:0]} + {3'b0, s2_sum_r[5:3]} + {3'b0, s2_sum_r[8:6]}
           + {3'b0, s2_sum_r[11:9]} + {4'b0, s2_sum_r[13:12]};
    fold_b = {1'b0, fold_a[5:3]} + {1'b0, fold_a[2:0]};
    wd_nxt = (fold_b >= 4'd7) ? 3'(fold_b - 4'd7) : fold_b[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_valid_res     <= s2_ok_r;
      out_leap          <= s2_ok_r && s2_lp_r;
      out_day_of_year   <= s2_ok_r ? s2_doy_r : '0;
      out_days_left     <= s2_ok_r ? (DAYS_IN_YEAR + {8'b0, s2_lp_r} - s2_doy_r) : '0;
      out_weekday       <= s2_ok_r ? wd_nxt : '0;
      out_next_year     <= s2_ok_r ? s2_ny_r : '0;
      out_next_month    <= s2_ok_r ? s2_nm_r : '0;
      out_next_day      <= s2_ok_r ? s2_nd_r : '0;
      out_prev_year     <= s2_ok_r ? s2_py_r : '0;
      out_prev_month    <= s2_ok_r ? s2_pm_r : '0;
      out_prev_day      <= s2_ok_r ? s2_pd_r : '0;
      out_step_overflow <= s2_ok_r ? s2_ovf_r : '0;
    end
  end

endmodule

/* design/gda_checker.sv */
// ----------------------------------------------------------------------------
// gda_checker: port-level assertions for the date analyser
// Watches the result channel for handshake hold, reset behaviour and
// consistency between the result fields.
// ----------------------------------------------------------------------------
module gda_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_valid_res,
  input logic                         out_leap,
  input logic [gda_pkg::DOY_W-1:0]    out_day_of_year,
  input logic [gda_pkg::DOY_W-1:0]    out_days_left,
  input logic [2:0]                   out_weekday,
  input logic [gda_pkg::YEAR_W-1:0]   out_next_year,
  input logic [3:0]                   out_next_month,
  input logic [4:0]                   out_next_day,
  input logic [gda_pkg::YEAR_W-1:0]   out_prev_year,
  input logic [3:0]                   out_prev_month,
  input logic [4:0]                   out_prev_day,
  input logic [1:0]                   out_step_overflow
);
  import gda_pkg::*;

  // hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day_of_year)
      && $stable(out_weekday) && $stable(out_valid_res) && $stable(out_next_year))
    else $error("stalled item changed");

  // drop all results out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> !out_leap && out_day_of_year == '0
      && out_days_left == '0 && out_weekday == '0 && out_next_year == '0
      && out_next_month == '0 && out_next_day == '0 && out_prev_year == '0
      && out_prev_month == '0 && out_prev_day == '0 && out_step_overflow == '0)
    else $error("invalid date carries non-zero fields");

  a_year_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_day_of_year != '0 && out_weekday <= 3'd6
      && (out_day_of_year + out_days_left == DAYS_IN_YEAR + {8'b0, out_leap}))
    else $error("day of year and days left disagree");

endmodule

bind gregorian_date_analyzer gda_checker u_gda_checker (.*);

/* dv/tb_gregorian_date_analyzer.sv */
// ----------------------------------------------------------------------------
// tb_gregorian_date_analyzer: self-checking bench for the date analyser
// Feeds dates through the valid/ready input under random bursts and output
// stalls, predicts each result in the bench and checks it field by field.
// The year window is reprogrammed between phases, covering the reset window,
// the full year range, an empty window, a single year and random windows.
// ----------------------------------------------------------------------------
module tb_gregorian_date_analyzer;
  import gda_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int TAIL_CYCLES    = 8;

  // Register slots beyond the two year limits; writes there must be ignored
  localparam logic [CFG_A_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [1:0] OVF_NEXT = 2'b01;
  localparam logic [1:0] OVF_PREV = 2'b10;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  typedef struct packed {
    logic              valid_res;
    logic              leap;
    logic [DOY_W-1:0]  day_of_year;
    logic [DOY_W-1:0]  days_left;
    logic [2:0]        weekday;
    logic [YEAR_W-1:0] next_year;
    logic [3:0]        next_month;
    logic [4:0]        next_day;
    logic [YEAR_W-1:0] prev_year;
    logic [3:0]        prev_month;
    logic [4:0]        prev_day;
    logic [1:0]        step_overflow;
  } cal_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  date_t cur_date = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_valid_res, out_leap;
  logic [DOY_W-1:0] out_day_of_year, out_days_left;
  logic [2:0] out_weekday;
  logic [YEAR_W-1:0] out_next_year, out_prev_year;
  logic [3:0] out_next_month, out_prev_month;
  logic [4:0] out_next_day, out_prev_day;
  logic [1:0] out_step_overflow;
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [YEAR_W-1:0] cfg_wdata = '0;

  // Bench copy of the year window
  logic [YEAR_W-1:0] win_low = YEAR_LOW_RST;
  logic [YEAR_W-1:0] win_high = YEAR_HIGH_RST;

  date_t    pend_dates[$];
  cal_res_t due_results[$];
  logic     in_took = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       ready_mode = 0;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     hold_req = 1'b0;
  int       idle_cycles = 0;
  int       fail_cnt = 0;

  always #4 clk = ~clk;

  gregorian_date_analyzer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_year          (cur_date.year),
    .in_month         (cur_date.month),
    .in_day           (cur_date.day),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_leap         (out_leap),
    .out_day_of_year  (out_day_of_year),
    .out_days_left    (out_days_left),
    .out_weekday      (out_weekday),
    .out_next_year    (out_next_year),
    .out_next_month   (out_next_month),
    .out_next_day     (out_next_day),
    .out_prev_year    (out_prev_year),
    .out_prev_month   (out_prev_month),
    .out_prev_day     (out_prev_day),
    .out_step_overflow(out_step_overflow),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic int unsigned leap_year(input int unsigned y);
    return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
  endfunction

  // Zero for a month number outside 1 to 12
  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = 28 + leap_year(y);
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic cal_res_t analyse_date(input date_t dt, input logic [YEAR_W-1:0] lo,
                                            input logic [YEAR_W-1:0] hi);
    cal_res_t r;
    int unsigned y, m, d, mlen, lp, doy, ny, nm, nd, py, pm, pd, yy, mp, cnt;
    logic [1:0] ovf;
    r = '0;
    y = dt.year;
    m = dt.month;
    d = dt.day;
    mlen = month_days(y, m);
    if (y < lo || y > hi || mlen == 0 || d < 1 || d > mlen)
      return r;
    lp = leap_year(y);
    doy = d;
    for (int unsigned k = 1; k < m; k++)
      doy += month_days(y, k);
    ny = y; nm = m; nd = d + 1;
    py = y; pm = m; pd = d - 1;
    ovf = '0;
    if (nd > mlen) begin
      nd = 1;
      nm = m + 1;
      if (nm > 12) begin
        nm = 1;
        ny = y + 1;
      end
    end
    if (pd == 0) begin
      if (m == 1) begin
        // year 0 steps back to 4095, flagged against the unwrapped year
        pm = 12;
        pd = 31;
        py = (y == 0) ? 4095 : y - 1;
        if (y == 0 || y - 1 < lo)
          ovf |= OVF_PREV;
      end else begin
        pm = m - 1;
        pd = month_days(y, pm);
      end
    end
    if (ny > hi)
      ovf |= OVF_NEXT;
    // day count from 1 March of year 0, shifted by 400 years; that day is a Wednesday
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    mp = (m + 9) % 12;
    cnt = 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
    r.valid_res     = 1'b1;
    r.leap          = lp[0];
    r.day_of_year   = doy[DOY_W-1:0];
    r.days_left     = DOY_W'(365 + lp - doy);
    r.weekday       = 3'((cnt + 3) % 7);
    r.next_year     = YEAR_W'(ny);
    r.next_month    = 4'(nm);
    r.next_day      = 5'(nd);
    r.prev_year     = YEAR_W'(py);
    r.prev_month    = 4'(pm);
    r.prev_day      = 5'(pd);
    r.step_overflow = ovf;
    return r;
  endfunction

  // Mostly real dates in the window, edges favoured; the rest raw noise
  function automatic date_t rand_date(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
    date_t dt;
    int unsigned pick, mlen;
    pick = $urandom_range(0, 9);
    if (pick < 2 || lo > hi) begin
      dt.year  = YEAR_W'($urandom_range(0, 4095));
      dt.month = MON_W'($urandom_range(0, 127));
      dt.day   = DAY_W'($urandom_range(0, 127));
      return dt;
    end
    case ($urandom_range(0, 9))
      0:       dt.year = lo;
      1:       dt.year = hi;
      default: dt.year = YEAR_W'($urandom_range(lo, hi));
    endcase
    case ($urandom_range(0, 7))
      0:       dt.month = MON_W'(1);
      1:       dt.month = MON_W'(12);
      2:       dt.month = MON_W'(2);
      default: dt.month = MON_W'($urandom_range(1, 12));
    endcase
    mlen = month_days(dt.year, dt.month);
    case ($urandom_range(0, 3))
      0:       dt.day = DAY_W'(1);
      1:       dt.day = DAY_W'(mlen);
      default: dt.day = DAY_W'($urandom_range(1, mlen));
    endcase
    return dt;
  endfunction

  task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d);
    date_t dt;
    dt.year  = YEAR_W'(y);
    dt.month = MON_W'(m);
    dt.day   = DAY_W'(d);
    pend_dates.push_back(dt);
  endtask

  task automatic set_reg(input logic [CFG_A_W-1:0] idx, input logic [YEAR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_YEAR_LOW:  win_low = val;
      REG_YEAR_HIGH: win_high = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued item is in and every result is out; test at the
  // rising edge, where the sender's queue and valid have settled
  task automatic drain();
    while (pend_dates.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) pend_dates.push_back(rand_date(win_low, win_high));
    drain();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Input side: predict each item as it is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      due_results.push_back(analyse_date(cur_date, win_low, win_high));
    in_took <= rst_n && in_valid && in_ready;
  end

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_dates.size() != 0) begin
        cur_date <= pend_dates.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes at random intervals; long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 96);
      ready_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result side: compare against the oldest prediction
  always @(posedge clk) begin
    cal_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result item with no item outstanding");
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("valid_res", want.valid_res, out_valid_res);
        check_field("leap", want.leap, out_leap);
        check_field("day_of_year", want.day_of_year, out_day_of_year);
        check_field("days_left", want.days_left, out_days_left);
        check_field("weekday", want.weekday, out_weekday);
        check_field("next_year", want.next_year, out_next_year);
        check_field("next_month", want.next_month, out_next_month);
        check_field("next_day", want.next_day, out_next_day);
        check_field("prev_year", want.prev_year, out_prev_year);
        check_field("prev_month", want.prev_month, out_prev_month);
        check_field("prev_day", want.prev_day, out_prev_day);
        check_field("step_overflow", want.step_overflow, out_step_overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gregorian_date_analyzer: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [YEAR_W-1:0] lo, hi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window 1700..2100
    add_date(1700, 1, 1);
    add_date(2100, 12, 31);
    add_date(2000, 2, 29);
    add_date(1900, 2, 29);
    add_date(1900, 2, 28);
    add_date(2024, 3, 1);
    add_date(2023, 2, 29);
    add_date(2023, 5, 31);
    add_date(2023, 4, 31);
    add_date(2023, 12, 31);
    add_date(2024, 0, 10);
    add_date(2024, 13, 1);
    add_date(2024, 127, 127);
    add_date(2024, 6, 0);
    add_date(1699, 12, 31);
    add_date(2101, 1, 1);
    drain();

    // Full year range, including both wraps and year 0
    set_reg(REG_YEAR_LOW, 12'd0);
    set_reg(REG_YEAR_HIGH, 12'd4095);
    add_date(0, 1, 1);
    add_date(4095, 12, 31);
    add_date(0, 2, 29);
    add_date(4095, 1, 1);
    add_date(2000, 12, 31);
    add_date(1, 1, 1);
    add_date(4095, 2, 29);
    drain();
    hold_req = 1'b1;
    run_random(300);

    set_reg(REG_SPARE_A, 12'd5);
    set_reg(REG_SPARE_B, 12'd4000);
    run_random(150);

    // Empty window
    set_reg(REG_YEAR_LOW, 12'd3000);
    set_reg(REG_YEAR_HIGH, 12'd2000);
    run_random(100);

    set_reg(REG_YEAR_LOW, 12'd2000);
    set_reg(REG_YEAR_HIGH, 12'd2000);
    run_random(150);

    repeat (4) begin
      lo = YEAR_W'($urandom_range(0, 4095));
      hi = (32'(lo) + 60 > 4095) ? 12'd4095 : lo + YEAR_W'($urandom_range(0, 60));
      set_reg(REG_YEAR_LOW, lo);
      set_reg(REG_YEAR_HIGH, hi);
      run_random(200);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("gregorian_date_analyzer: match");
    else
      $display("gregorian_date_analyzer: mismatch");
    $finish;
  end

endmodule
